// File: sv/time_table_interpolator_top_assert.svh
// Assertion macros for the time table interpolator.
`ifndef TIME_TABLE_INTERPOLATOR_TOP_ASSERT_SVH
`define TIME_TABLE_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TTI_A_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TTI_A_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TTI_A_IMP(lbl, ante, cons, msg)
`define TTI_A_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/tti_pkg.sv
// Shared types and constants of the time table interpolator.
package tti_pkg;
  localparam int MAX_ROWS_DEF     = 256;
  localparam int MAX_CHANNELS_DEF = 8;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_ROW_COUNT     = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] CFG_INTERP_MODE   = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [7:0]  row_index;
    logic [3:0]  column_index;
    logic [31:0] entry_word;
    logic [31:0] query_time;
  } in_t;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [31:0] output_value;
    logic               last_channel;
  } out_t;

  typedef struct packed {
    logic        found;
    logic        past_last;
    logic [31:0] t0;
    logic [31:0] t1;
  } scan_res_t;
endpackage

// File: sv/tti_scan.sv
// Row time memory and the sequential segment search over it.
module tti_scan import tti_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(MAX_ROWS)-1:0] wr_addr,
  input  logic [31:0]                 wr_data,
  input  logic                        start,
  input  logic [31:0]                 query_time,
  input  logic [$clog2(MAX_ROWS):0]   rows,
  output logic                        done,
  output scan_res_t                   res,
  output logic [$clog2(MAX_ROWS)-1:0] seg
);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = RW + 1;
  localparam logic SC_IDLE = 1'b0;
  localparam logic SC_RUN  = 1'b1;

  logic [31:0]   tmem [MAX_ROWS];
  logic [31:0]   rdata_r;
  logic          st_r;
  logic [RW-1:0] kd_r;
  logic [RW-1:0] raddr;
  logic [31:0]   prev_r;
  logic [31:0]   t_r;
  logic [CW-1:0] rows_r;
  logic          done_r;
  scan_res_t     res_r;
  logic [RW-1:0] seg_r;
  logic          hit;
  logic          at_end;

  assign raddr  = (st_r == SC_RUN) ? RW'(kd_r + 1'b1) : '0;
  assign hit    = (kd_r != '0) && (t_r >= prev_r) && (t_r <= rdata_r);
  assign at_end = ({1'b0, kd_r} == CW'(rows_r - 1'b1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tmem[wr_addr] <= wr_data;
    end
    rdata_r <= tmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SC_IDLE;
      done_r <= 1'b0;
      kd_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (st_r == SC_IDLE) begin
        if (start) begin
          st_r <= SC_RUN;
          kd_r <= '0;
        end
      end else begin
        if (hit || at_end) begin
          done_r <= 1'b1;
          st_r   <= SC_IDLE;
        end else begin
          kd_r <= RW'(kd_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == SC_IDLE && start) begin
      t_r    <= query_time;
      rows_r <= rows;
    end
    if (st_r == SC_RUN) begin
      prev_r <= rdata_r;
      if (hit || at_end) begin
        res_r.found     <= hit;
        res_r.past_last <= !hit && (t_r >= rdata_r);
        res_r.t0        <= prev_r;
        res_r.t1        <= rdata_r;
        seg_r           <= RW'(kd_r - 1'b1);
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign seg  = seg_r;
endmodule

// File: sv/tti_lerp.sv
// Serial interpolation unit: shift-add multiply then restoring divide.
module tti_lerp import tti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] t,
  input  logic [31:0] t0,
  input  logic [31:0] t1,
  input  logic [31:0] y0,
  input  logic [31:0] y1,
  output logic        done,
  output logic [31:0] result
);
  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_DIV  = 3'd2;
  localparam logic [2:0] L_FIN  = 3'd3;
  localparam logic [2:0] L_DONE = 3'd4;

  logic [2:0]  st_r;
  logic [5:0]  cnt_r;
  logic [32:0] mag_r;
  logic        neg_r;
  logic [31:0] dt_r;
  logic [31:0] span_r;
  logic [64:0] acc_r;
  logic [64:0] acc_nxt;
  logic [31:0] rem_r;
  logic [32:0] low_r;
  logic [32:0] q_r;
  logic [31:0] y0_r;
  logic [31:0] res_r;
  logic [32:0] dy;
  logic [32:0] rem2;
  logic [32:0] diff;
  logic        ge;

  assign dy      = {y1[31], y1} - {y0[31], y0};
  assign acc_nxt = {acc_r[63:0], 1'b0} + (dt_r[31] ? {32'd0, mag_r} : 65'd0);
  assign rem2    = {rem_r, low_r[32]};
  assign diff    = rem2 - {1'b0, span_r};
  assign ge      = (rem2 >= {1'b0, span_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= L_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        L_IDLE: begin
          if (start) begin
            cnt_r <= '0;
            st_r  <= (t1 <= t0) ? L_DONE : L_MUL;
          end
        end
        L_MUL: begin
          if (cnt_r == 6'd31) begin
            cnt_r <= '0;
            st_r  <= L_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        L_DIV: begin
          if (cnt_r == 6'd32) begin
            st_r <= L_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        L_FIN:   st_r <= L_DONE;
        L_DONE:  st_r <= L_IDLE;
        default: st_r <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      L_IDLE: begin
        if (start) begin
          y0_r   <= y0;
          res_r  <= y0;
          neg_r  <= dy[32];
          mag_r  <= dy[32] ? 33'(-dy) : dy;
          dt_r   <= t - t0;
          span_r <= t1 - t0;
          acc_r  <= '0;
        end
      end
      L_MUL: begin
        acc_r <= acc_nxt;
        dt_r  <= {dt_r[30:0], 1'b0};
        if (cnt_r == 6'd31) begin
          rem_r <= acc_nxt[64:33];
          low_r <= acc_nxt[32:0];
        end
      end
      L_DIV: begin
        rem_r <= ge ? diff[31:0] : rem2[31:0];
        low_r <= {low_r[31:0], 1'b0};
        q_r   <= {q_r[31:0], ge};
      end
      L_FIN: begin
        res_r <= neg_r ? (y0_r - q_r[31:0]) : (y0_r + q_r[31:0]);
      end
      default: begin
      end
    endcase
  end

  assign done   = (st_r == L_DONE);
  assign result = res_r;
endmodule

// File: sv/time_table_interpolator_top.sv
// Time table interpolator: value memory, channel sequencer and result register.
// A query with two or more rows scans them, then per channel emits zero, the held value,
// a stored row value or a value interpolated by the serial multiply and divide unit; a new
// table write or query is taken only in idle, after the previous query has finished.
// Reset clears configuration to defaults and the held outputs to zero;
// the time and value memories are not cleared.
`include "time_table_interpolator_top_assert.svh"
module time_table_interpolator_top import tti_pkg::*; #(
  parameter int MAX_ROWS     = MAX_ROWS_DEF,
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = RW + 1;
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW  = CHW + 1;
  localparam int VW  = $clog2(MAX_ROWS * MAX_CHANNELS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD0  = 3'd2;
  localparam logic [2:0] S_RD1  = 3'd3;
  localparam logic [2:0] S_RD2  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [1:0] K_ZERO = 2'd0;
  localparam logic [1:0] K_HELD = 2'd1;
  localparam logic [1:0] K_ROW  = 2'd2;
  localparam logic [1:0] K_LERP = 2'd3;

  logic [8:0]     row_count_r;
  logic [3:0]     channel_count_r;
  logic           interp_r;
  logic [CW-1:0]  rows_c;
  logic [NW-1:0]  chans_c;
  logic [CW-1:0]  rows_r;
  logic [NW-1:0]  chans_r;
  logic           mode_r;
  logic [31:0]    t_r;
  logic [2:0]     state_r;
  logic [1:0]     kind_r;
  logic [CHW-1:0] j_r;
  logic [VW-1:0]  base_r;
  logic [31:0]    y0_r;
  logic [31:0]    result_r;
  logic [31:0]    held_r [MAX_CHANNELS];
  logic           out_valid_r;
  out_t           out_r;

  logic           in_fire;
  logic           wr_ok;
  logic           t_wr;
  logic           v_wr;
  logic [VW-1:0]  v_waddr;
  logic [VW-1:0]  vaddr;
  logic [31:0]    vmem [MAX_ROWS * MAX_CHANNELS];
  logic [31:0]    vrdata_r;
  logic           scan_start;
  logic           scan_done;
  scan_res_t      scan_res;
  logic [RW-1:0]  scan_seg;
  logic [RW-1:0]  row_sel;
  logic           lerp_start;
  logic           lerp_done;
  logic [31:0]    lerp_res;
  logic           emit_go;
  logic           is_last;
  logic [31:0]    emit_val;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (32'(row_count_r) > 32'(MAX_ROWS)) begin
      rows_c = CW'(MAX_ROWS);
    end else begin
      rows_c = CW'(row_count_r);
    end
    if (channel_count_r == 4'd0) begin
      chans_c = NW'(1);
    end else if (32'(channel_count_r) > 32'(MAX_CHANNELS)) begin
      chans_c = NW'(MAX_CHANNELS);
    end else begin
      chans_c = NW'(channel_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= '0;
      channel_count_r <= 4'd1;
      interp_r        <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:     row_count_r     <= cfg_data;
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[3:0];
        CFG_INTERP_MODE:   interp_r        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // table writes
  assign wr_ok   = in_fire && (in_data.operation == OP_WRITE) &&
                   (32'(in_data.row_index) < 32'(MAX_ROWS));
  assign t_wr    = wr_ok && (in_data.column_index == 4'd0);
  assign v_wr    = wr_ok && (in_data.column_index != 4'd0) &&
                   (32'(in_data.column_index) <= 32'(MAX_CHANNELS));
  assign v_waddr = VW'(VW'(in_data.row_index) * VW'(MAX_CHANNELS)) +
                   VW'(in_data.column_index - 4'd1);

  assign vaddr = base_r + VW'(j_r) + ((state_r == S_RD1) ? VW'(MAX_CHANNELS) : VW'(0));

  always_ff @(posedge clk) begin
    if (v_wr) begin
      vmem[v_waddr] <= in_data.entry_word;
    end
    vrdata_r <= vmem[vaddr];
  end

  assign scan_start = in_fire && (in_data.operation == OP_QUERY) && (rows_c >= CW'(2));

  tti_scan #(.MAX_ROWS(MAX_ROWS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (t_wr),
    .wr_addr   (RW'(in_data.row_index)),
    .wr_data   (in_data.entry_word),
    .start     (scan_start),
    .query_time(in_data.query_time),
    .rows      (rows_c),
    .done      (scan_done),
    .res       (scan_res),
    .seg       (scan_seg)
  );

  assign lerp_start = (state_r == S_RD2);

  tti_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .t     (t_r),
    .t0    (scan_res.t0),
    .t1    (scan_res.t1),
    .y0    (y0_r),
    .y1    (vrdata_r),
    .done  (lerp_done),
    .result(lerp_res)
  );

  assign row_sel = scan_res.found ? scan_seg : RW'(rows_r - 1'b1);
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign is_last = ({1'b0, j_r} + 1'b1) == chans_r;

  always_comb begin
    unique case (kind_r)
      K_ZERO:  emit_val = '0;
      K_HELD:  emit_val = held_r[j_r];
      default: emit_val = result_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      kind_r      <= K_ZERO;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        held_r[k] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_data.operation == OP_QUERY) begin
            j_r <= '0;
            if (rows_c == '0) begin
              kind_r  <= K_ZERO;
              state_r <= S_EMIT;
            end else if (rows_c == CW'(1)) begin
              kind_r  <= K_HELD;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            if (scan_res.found) begin
              kind_r  <= mode_r ? K_LERP : K_ROW;
              state_r <= S_RD0;
            end else if (scan_res.past_last) begin
              kind_r  <= K_ROW;
              state_r <= S_RD0;
            end else begin
              kind_r  <= K_HELD;
              state_r <= S_EMIT;
            end
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: state_r <= (kind_r == K_LERP) ? S_RD2 : S_EMIT;
        S_RD2: state_r <= S_DIV;
        S_DIV: begin
          if (lerp_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            held_r[j_r] <= emit_val;
            if (is_last) begin
              state_r <= S_IDLE;
            end else begin
              j_r     <= CHW'(j_r + 1'b1);
              state_r <= (kind_r == K_ZERO || kind_r == K_HELD) ? S_EMIT : S_RD0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.operation == OP_QUERY) begin
      rows_r  <= rows_c;
      chans_r <= chans_c;
      mode_r  <= interp_r;
      t_r     <= in_data.query_time;
    end
    if (state_r == S_SCAN && scan_done) begin
      base_r <= VW'(VW'(row_sel) * VW'(MAX_CHANNELS));
    end
    if (state_r == S_RD1) begin
      y0_r     <= vrdata_r;
      result_r <= vrdata_r;
    end
    if (state_r == S_DIV && lerp_done) begin
      result_r <= lerp_res;
    end
    if (emit_go) begin
      out_r.channel      <= 3'(j_r);
      out_r.output_value <= emit_val;
      out_r.last_channel <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TTI_A_NXT(a_last_to_idle, emit_go && is_last, state_r == S_IDLE, "last channel did not end query")
  `TTI_A_IMP(a_lerp_in_div, lerp_done, state_r == S_DIV, "divider finished outside wait state")
  `TTI_A_IMP(a_scan_in_scan, scan_done, state_r == S_SCAN, "scan finished outside scan state")
  `TTI_A_IMP(a_chan_range, state_r == S_EMIT, {1'b0, j_r} < chans_r, "channel index past count")
endmodule
